/* rtl/bfrr_pkg.sv */
// shared types and constants for the broadcast fifo with all-read release
package bfrr_pkg;

    localparam int DEPTH          = 16;
    localparam int CONSUMERS      = 2;
    localparam int PTR_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W          = $clog2(DEPTH + 1);
    localparam int ID_W           = 1;
    localparam int DATA_W         = 8;
    localparam int MF_W           = 5;
    localparam int STATUS_W       = 3;
    localparam int CMP_W          = (CNT_W > MF_W) ? CNT_W : MF_W;
    localparam logic [MF_W-1:0] MIN_FILL_RESET = MF_W'(3);

    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 3'd0,
        ST_READ   = 3'd1,
        ST_FULL   = 3'd2,
        ST_FEW    = 3'd3,
        ST_SEEN   = 3'd4
    } t_status;

    typedef struct packed {
        t_func             func;
        logic [DATA_W-1:0] push_data;
        logic [ID_W-1:0]   consumer_id;
    } t_op;

    typedef struct packed {
        t_status           status;
        logic [DATA_W-1:0] read_data;
        logic              removed;
        logic [CNT_W-1:0]  fill_count;
    } t_result;

endpackage

/* rtl/bfrr_ctrl.sv */
// ring storage, pointers, read mask and the per-item decision logic
module bfrr_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  bfrr_pkg::t_op             i_op,
    input  logic [bfrr_pkg::MF_W-1:0] i_min_fill,
    output bfrr_pkg::t_result         o_result
);
    import bfrr_pkg::*;

    logic [DATA_W-1:0]    r_store [DEPTH];
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CONSUMERS-1:0] r_mask, n_mask;
    logic                 wr_en;
    logic                 id_ok;

    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_mask   = r_mask;
        wr_en    = 1'b0;
        id_ok    = int'(i_op.consumer_id) < CONSUMERS;
        o_result = '{status: ST_FEW, read_data: '0, removed: 1'b0, fill_count: '0};
        case (i_op.func)
            FUNC_PUSH: begin
                if (r_count >= CNT_W'(DEPTH)) begin
                    o_result.status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_tail  = (r_tail == PTR_W'(DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    n_count = r_count + 1'b1;
                    o_result.status = ST_PUSHED;
                end
            end
            FUNC_POP: begin
                if (r_count == '0 || CMP_W'(r_count) < CMP_W'(i_min_fill)) begin
                    o_result.status = ST_FEW;
                end else if (!id_ok || r_mask[i_op.consumer_id]) begin
                    o_result.status = ST_SEEN;
                end else begin
                    n_mask[i_op.consumer_id] = 1'b1;
                    o_result.status    = ST_READ;
                    o_result.read_data = r_store[r_head];
                    // last consumer marked: release head and clear mask
                    if (&n_mask) begin
                        n_head  = (r_head == PTR_W'(DEPTH - 1)) ? '0 : r_head + 1'b1;
                        n_count = r_count - 1'b1;
                        n_mask  = '0;
                        o_result.removed = 1'b1;
                    end
                end
            end
            default: begin
                o_result.status = ST_FEW;
            end
        endcase
        o_result.fill_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_mask  <= '0;
        end else if (i_fire) begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_mask  <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && wr_en) begin
            r_store[r_tail] <= i_op.push_data;
        end
    end

endmodule

/* rtl/broadcast_fifo_all_read_release_unit.sv */
// top level of the multi-reader broadcast byte fifo
//
// usage:
//   input channel (i_valid / o_ready) carries one operation per item:
//   i_func selects push (store i_push_data at the tail) or pop (consumer
//   i_consumer_id reads the head). output channel (o_valid / i_ready)
//   returns exactly one result item per input item: status, read byte,
//   head-released flag and the fill count after the operation.
//   config channel (i_cfg_valid / o_cfg_ready) writes min_fill; it is
//   always ready and must only be written while the block is idle.
// timing:
//   an item goes into an input register, is decided by one pass of
//   combinational logic against the fifo state and lands in the result
//   register; one item per cycle is sustained while the receiver keeps
//   taking results.
// reset: synchronous active low; fifo empty, read mask clear, min_fill 3;
//   byte storage keeps no reset and is only read where written.
// stall: when the receiver holds i_ready low, the result register holds,
//   one more item may wait in the input register, then o_ready drops.
module broadcast_fifo_all_read_release_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [bfrr_pkg::DATA_W-1:0]   i_push_data,
    input  logic [bfrr_pkg::ID_W-1:0]     i_consumer_id,
    // result channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bfrr_pkg::STATUS_W-1:0] o_status,
    output logic [bfrr_pkg::DATA_W-1:0]   o_read_data,
    output logic                          o_removed,
    output logic [bfrr_pkg::CNT_W-1:0]    o_fill_count,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfrr_pkg::MF_W-1:0]     i_cfg_min_fill
);
    import bfrr_pkg::*;

    // input register stage
    logic      r_in_valid;
    t_op       r_in_op;
    // result register stage
    logic      r_out_valid;
    t_result   r_out;
    // min_fill register
    logic [MF_W-1:0] r_min_fill;

    t_result   core_result;
    logic      fire;

    // the decision fires when the result slot is free or being emptied
    assign fire        = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || fire;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_op <= '{func: t_func'(i_func), push_data: i_push_data,
                         consumer_id: i_consumer_id};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= core_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fill <= MIN_FILL_RESET;
        end else if (i_cfg_valid) begin
            r_min_fill <= i_cfg_min_fill;
        end
    end

    bfrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_op       (r_in_op),
        .i_min_fill (r_min_fill),
        .o_result   (core_result)
    );

    assign o_valid      = r_out_valid;
    assign o_status     = r_out.status;
    assign o_read_data  = r_out.read_data;
    assign o_removed    = r_out.removed;
    assign o_fill_count = r_out.fill_count;

    // a head release only comes with a successful read
    a_removed_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_removed) |-> (r_out.status == ST_READ))
        else $error("head released on a non-read result");

    // read byte is zero for every status other than read
    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_out.status != ST_READ) |-> (o_read_data == '0))
        else $error("read data nonzero on non-read result");

    // fill count never passes the ring depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_fill_count <= CNT_W'(DEPTH)))
        else $error("fill count above depth");

    // a result slot taken while no new decision arrives empties next cycle
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !fire) |=> !o_valid)
        else $error("result register did not drain");

endmodule

/* bench/testbench.sv */
// self-checking testbench for the broadcast byte fifo: directed table, then random phases
`timescale 1ns / 100ps

module testbench;
    import bfrr_pkg::*;

    // one directed row: operation, and the result where it is plain to see
    typedef struct packed {
        t_func             func;
        logic [DATA_W-1:0] data;
        logic [ID_W-1:0]   id;
        logic              typed;
        t_status           st;
        logic [DATA_W-1:0] rd;
        logic              rm;
        logic [CNT_W-1:0]  fc;
    } t_op_row;

    localparam int NUM_ROWS = 24;
    // min_fill starts at its reset value of 3
    localparam t_op_row OP_ROWS [NUM_ROWS] = '{
        '{FUNC_POP,  8'h00, 1'b0, 1'b1, ST_FEW,    8'h00, 1'b0, 5'd0},  // pop on empty
        '{FUNC_PUSH, 8'h00, 1'b1, 1'b1, ST_PUSHED, 8'h00, 1'b0, 5'd1},
        '{FUNC_PUSH, 8'hff, 1'b0, 1'b1, ST_PUSHED, 8'h00, 1'b0, 5'd2},
        '{FUNC_POP,  8'h00, 1'b1, 1'b1, ST_FEW,    8'h00, 1'b0, 5'd2},  // below min_fill
        '{FUNC_PUSH, 8'ha5, 1'b0, 1'b1, ST_PUSHED, 8'h00, 1'b0, 5'd3},
        '{FUNC_POP,  8'h00, 1'b0, 1'b1, ST_READ,   8'h00, 1'b0, 5'd3},
        '{FUNC_POP,  8'h00, 1'b0, 1'b1, ST_SEEN,   8'h00, 1'b0, 5'd3},  // same reader twice
        '{FUNC_POP,  8'hff, 1'b1, 1'b1, ST_READ,   8'h00, 1'b1, 5'd2},  // last reader releases
        '{FUNC_POP,  8'h00, 1'b1, 1'b1, ST_FEW,    8'h00, 1'b0, 5'd2},
        '{FUNC_PUSH, 8'h01, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h02, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h04, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h08, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h10, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h20, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h40, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h80, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h55, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'haa, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'hfe, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h7f, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'h3c, 1'b0, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},
        '{FUNC_PUSH, 8'hc3, 1'b1, 1'b0, ST_PUSHED, 8'h00, 1'b0, 5'd0},  // now 16 held
        '{FUNC_PUSH, 8'h99, 1'b1, 1'b1, ST_FULL,   8'h00, 1'b0, 5'd16}  // push when full
    };

    // random phases: min_fill setting and share of push bursts in percent
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_ITEMS = 172;
    localparam int LONG_HOLD   = 64;
    localparam int PHASE_MF   [NUM_PHASES] = '{0, 16, 31, 1, 0, 8, 17, 15, 4, 2, 0};
    localparam int PHASE_PUSH [NUM_PHASES] = '{35, 65, 50, 50, 55, 45, 60, 60, 40, 50, 50};

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic                i_func;
    logic [DATA_W-1:0]   i_push_data;
    logic [ID_W-1:0]     i_consumer_id;
    logic                o_valid;
    logic                i_ready;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_read_data;
    logic                o_removed;
    logic [CNT_W-1:0]    o_fill_count;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [MF_W-1:0]     i_cfg_min_fill;

    broadcast_fifo_all_read_release_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_push_data    (i_push_data),
        .i_consumer_id  (i_consumer_id),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_read_data    (o_read_data),
        .o_removed      (o_removed),
        .o_fill_count   (o_fill_count),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_min_fill (i_cfg_min_fill)
    );

    // shadow fifo state
    logic [DATA_W-1:0]    fifo_bytes [DEPTH];
    logic [PTR_W-1:0]     head_ptr = '0;
    logic [PTR_W-1:0]     tail_ptr = '0;
    int                   held_count = 0;
    logic [CONSUMERS-1:0] read_mask = '0;
    int                   min_fill_cfg = int'(MIN_FILL_RESET);

    t_result pending_results [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      status_seen [5] = '{0, 0, 0, 0, 0};
    int      releases_seen = 0;
    bit      long_hold_req = 1'b0;
    bit      calm = 1'b0;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #6_000_000;
        $display("broadcast_fifo_all_read_release_unit regression: fail");
        $finish;
    end

    function automatic logic [PTR_W-1:0] next_slot(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // one push or pop against the shadow state
    function automatic t_result predict_fifo_op(t_func f, logic [DATA_W-1:0] data,
                                                logic [ID_W-1:0] id);
        t_result r;
        r.status    = ST_PUSHED;
        r.read_data = '0;
        r.removed   = 1'b0;
        if (f == FUNC_PUSH) begin
            if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                fifo_bytes[tail_ptr] = data;
                tail_ptr = next_slot(tail_ptr);
                held_count++;
            end
        end else if (held_count == 0 || held_count < min_fill_cfg) begin
            // empty is refused even with min_fill 0
            r.status = ST_FEW;
        end else if (read_mask[id]) begin
            r.status = ST_SEEN;
        end else begin
            read_mask[id] = 1'b1;
            r.status      = ST_READ;
            r.read_data   = fifo_bytes[head_ptr];
            if (&read_mask) begin
                head_ptr   = next_slot(head_ptr);
                held_count--;
                read_mask  = '0;
                r.removed  = 1'b1;
            end
        end
        r.fill_count = CNT_W'(held_count);
        return r;
    endfunction

    // entered at a falling edge, returns at the falling edge after acceptance
    task automatic issue_op(t_func f, logic [DATA_W-1:0] data, logic [ID_W-1:0] id,
                            bit use_typed, t_result typed_res);
        t_result r;
        i_valid       <= 1'b1;
        i_func        <= f;
        i_push_data   <= data;
        i_consumer_id <= id;
        do @(posedge i_clk); while (!o_ready);
        r = predict_fifo_op(f, data, id);
        pending_results.push_back(use_typed ? typed_res : r);
        items_sent++;
        @(negedge i_clk);
    endtask

    // occasional random sender gap, none in the calm phase
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    // stop offering until every result is back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_min_fill(int value);
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_min_fill <= MF_W'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
        min_fill_cfg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: short random stalls, one long hold on request, none at the end
    initial begin
        bit hold_served;
        hold_served = 1'b0;
        i_ready     = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: status %0d", o_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_read_data !== want.read_data) begin
                    $error("read_data: expected %0h, got %0h", want.read_data, o_read_data);
                    mismatches++;
                end
                if (o_removed !== want.removed) begin
                    $error("removed: expected %0d, got %0d", want.removed, o_removed);
                    mismatches++;
                end
                if (o_fill_count !== want.fill_count) begin
                    $error("fill_count: expected %0d, got %0d", want.fill_count,
                           o_fill_count);
                    mismatches++;
                end
            end
            if (o_status <= ST_SEEN) status_seen[o_status]++;
            if (o_removed === 1'b1) releases_seen++;
        end
    end

    // stimulus
    initial begin
        t_op_row row;
        t_result typed_res;
        int      done;
        int      pick;
        int      mf;
        int      c;
        bit      quiet_done;

        quiet_done     = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_func         = 1'b0;
        i_push_data    = '0;
        i_consumer_id  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_min_fill = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < NUM_ROWS; n++) begin
            row = OP_ROWS[n];
            typed_res.status     = row.st;
            typed_res.read_data  = row.rd;
            typed_res.removed    = row.rm;
            typed_res.fill_count = row.fc;
            maybe_pause();
            issue_op(row.func, row.data, row.id, row.typed, typed_res);
        end

        // random phases, each under its own min_fill
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            mf = (ph == NUM_PHASES - 1) ? $urandom_range(0, 31) : PHASE_MF[ph];
            write_min_fill(mf);
            if (ph == NUM_PHASES - 1) calm = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) begin
                if (ph == 1 && done >= 40 && done < 44) long_hold_req = 1'b1;
                if (ph == 3 && done >= 80 && !quiet_done) begin
                    quiet_done = 1'b1;
                    drain_results();
                end
                pick = $urandom_range(0, 99);
                if (pick < PHASE_PUSH[ph]) begin
                    // burst of pushes
                    repeat ($urandom_range(1, 4)) begin
                        maybe_pause();
                        issue_op(FUNC_PUSH, DATA_W'($urandom), ID_W'($urandom), 1'b0,
                                 typed_res);
                        done++;
                    end
                end else if (pick < 90) begin
                    // both readers take the head, in random order
                    c = $urandom_range(0, 1);
                    maybe_pause();
                    issue_op(FUNC_POP, DATA_W'($urandom), ID_W'(c), 1'b0, typed_res);
                    maybe_pause();
                    issue_op(FUNC_POP, DATA_W'($urandom), ID_W'(1 - c), 1'b0, typed_res);
                    done += 2;
                end else begin
                    // lone pop, often a repeat read
                    maybe_pause();
                    issue_op(FUNC_POP, DATA_W'($urandom), ID_W'($urandom), 1'b0,
                             typed_res);
                    done++;
                end
            end
        end

        drain_results();
        repeat (4) @(negedge i_clk);
        $display("covered %0d items over %0d min_fill settings, 0 and 31 among them",
                 items_sent, NUM_PHASES + 1);
        $display("seen: %0d pushes, %0d reads, %0d releases, %0d full, %0d too few, %0d repeat",
                 status_seen[ST_PUSHED], status_seen[ST_READ], releases_seen,
                 status_seen[ST_FULL], status_seen[ST_FEW], status_seen[ST_SEEN]);
        if (mismatches == 0) begin
            $display("broadcast_fifo_all_read_release_unit regression: pass");
        end else begin
            $display("broadcast_fifo_all_read_release_unit regression: fail");
        end
        $finish;
    end

endmodule

/* broadcast_fifo_all_read_release_unit.f */
rtl/bfrr_pkg.sv
rtl/bfrr_ctrl.sv
rtl/broadcast_fifo_all_read_release_unit.sv
bench/testbench.sv
